@@ rtl/nonpreemptive_process_scheduler_assert.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef NONPREEMPTIVE_PROCESS_SCHEDULER_ASSERT_SVH
`define NONPREEMPTIVE_PROCESS_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nps assertion failed");

// Next-cycle implication, checked out of reset.
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nps assertion failed");

`endif

@@ rtl/nps_pkg.sv @@
// Package: shared types, policy codes and the dispatch ordering function.
`default_nettype none

package nps_pkg;

    localparam int MAX_PROCS_DEF = 16;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;

    typedef logic [1:0]  t_policy;
    typedef logic [15:0] t_tick;
    typedef logic [7:0]  t_prio;
    typedef logic [3:0]  t_pid;
    typedef logic [20:0] t_time;
    typedef logic [19:0] t_span;

    typedef struct packed {
        t_tick arr;
        t_tick burst;
        t_prio prio;
    } t_rec;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_issue;
        logic pick;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic last_pick;
    } t_stat;

    // True if record a goes ahead of record b; ties on every key give false,
    // so the lower id (seen first in the scan) wins.
    function automatic logic better(input t_policy pol, input t_rec a, input t_rec b);
        logic res;
        res = 1'b0;
        case (pol)
            POL_SJF: begin
                if (a.burst != b.burst) res = (a.burst < b.burst);
                else res = (a.arr < b.arr);
            end
            POL_PRIO: begin
                if (a.prio != b.prio) res = (a.prio > b.prio);
                else if (a.arr != b.arr) res = (a.arr < b.arr);
                else res = (a.burst < b.burst);
            end
            default: begin
                if (a.arr != b.arr) res = (a.arr < b.arr);
                else res = (a.burst < b.burst);
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nps_ctrl.sv @@
// Controller: load, scan, pick and result sequencing.
`default_nettype none

`include "nonpreemptive_process_scheduler_assert.svh"

module nps_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_last_process,
    input  wire logic          i_out_ready,
    input  wire nps_pkg::t_stat i_stat,
    output nps_pkg::t_cmd      o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = (r_state == S_LOAD);
        o_out_valid = (r_state == S_OUT);
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_process) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_stat.last_pick) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `NPS_ASSERT_SAME(a_no_load_while_out, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `NPS_ASSERT_NEXT(a_pick_shows_result, i_clk, i_rst_n, o_cmd.pick, o_out_valid)

endmodule

`default_nettype wire

@@ rtl/nps_dpath.sv @@
// Datapath: record memory, scan compare, run clock and result registers.
`default_nettype none

`include "nonpreemptive_process_scheduler_assert.svh"

module nps_dpath #(
    parameter int MAX_PROCS = nps_pkg::MAX_PROCS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire nps_pkg::t_cmd    i_cmd,
    output nps_pkg::t_stat        o_stat,
    input  wire logic             i_cfg_we,
    input  wire nps_pkg::t_policy i_cfg_policy,
    input  wire nps_pkg::t_tick   i_arrival_time,
    input  wire nps_pkg::t_tick   i_burst_time,
    input  wire nps_pkg::t_prio   i_priority_req,
    output nps_pkg::t_pid         o_process_id,
    output nps_pkg::t_time        o_start_time,
    output nps_pkg::t_time        o_completion_time,
    output nps_pkg::t_span        o_turnaround_time,
    output nps_pkg::t_span        o_waiting_time,
    output nps_pkg::t_span        o_response_time,
    output logic                  o_last_result
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    // Room for every burst stacked after the latest arrival.
    localparam int CLK_W = 17 + $clog2(MAX_PROCS);

    nps_pkg::t_rec r_mem [MAX_PROCS];
    nps_pkg::t_rec r_rd_data;

    nps_pkg::t_policy   r_policy;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_picks;
    logic [CNT_W-1:0]   r_idx;
    logic [CLK_W-1:0]   r_clock;
    logic [MAX_PROCS-1:0] r_done;
    logic               r_cmp_valid;
    logic [IDX_W-1:0]   r_cmp_idx;

    // Best arrived candidate and best of the earliest-arrival group.
    logic               r_fa;
    nps_pkg::t_rec      r_ba;
    logic [IDX_W-1:0]   r_ba_idx;
    logic               r_fe;
    nps_pkg::t_rec      r_be;
    logic [IDX_W-1:0]   r_be_idx;

    nps_pkg::t_pid      r_pid;
    nps_pkg::t_time     r_start;
    nps_pkg::t_time     r_comp;
    nps_pkg::t_span     r_tat;
    nps_pkg::t_span     r_resp;
    logic               r_last;

    logic               n_store;
    logic               n_issue;
    logic               n_undone;
    logic               n_take_a;
    logic               n_take_e;
    nps_pkg::t_rec      n_rec;
    logic [IDX_W-1:0]   n_pick_idx;
    logic [CLK_W-1:0]   n_start;
    logic [CLK_W-1:0]   n_comp;
    logic [CLK_W-1:0]   n_resp;
    logic [CLK_W-1:0]   n_tat;

    always_comb begin
        n_store  = i_cmd.load && (r_count < CNT_W'(MAX_PROCS));
        n_issue  = i_cmd.scan_issue && (r_idx < r_count);
        n_undone = r_cmp_valid && !r_done[r_cmp_idx];
        n_take_a = n_undone && (CLK_W'(r_rd_data.arr) <= r_clock) &&
                   (!r_fa || nps_pkg::better(r_policy, r_rd_data, r_ba));
        n_take_e = n_undone &&
                   (!r_fe || (r_rd_data.arr < r_be.arr) ||
                    ((r_rd_data.arr == r_be.arr) &&
                     nps_pkg::better(r_policy, r_rd_data, r_be)));
        // Nothing arrived: jump the clock to the earliest group's arrival.
        n_rec      = r_fa ? r_ba : r_be;
        n_pick_idx = r_fa ? r_ba_idx : r_be_idx;
        n_start    = r_fa ? r_clock : CLK_W'(r_be.arr);
        n_comp     = n_start + CLK_W'(n_rec.burst);
        n_resp     = n_start - CLK_W'(n_rec.arr);
        n_tat      = n_comp - CLK_W'(n_rec.arr);
    end

    always_ff @(posedge i_clk) begin
        if (n_store) begin
            r_mem[r_count[IDX_W-1:0]] <= '{arr: i_arrival_time, burst: i_burst_time,
                                           prio: i_priority_req};
        end
        if (n_issue) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= nps_pkg::POL_FCFS;
            r_count     <= '0;
            r_picks     <= '0;
            r_idx       <= '0;
            r_clock     <= '0;
            r_done      <= '0;
            r_cmp_valid <= 1'b0;
            r_fa        <= 1'b0;
            r_fe        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_policy;
            end
            if (n_store) begin
                r_count <= r_count + 1'b1;
            end
            r_cmp_valid <= n_issue;
            if (n_issue) begin
                r_idx     <= r_idx + 1'b1;
                r_cmp_idx <= r_idx[IDX_W-1:0];
            end
            if (n_take_a) begin
                r_fa     <= 1'b1;
                r_ba     <= r_rd_data;
                r_ba_idx <= r_cmp_idx;
            end
            if (n_take_e) begin
                r_fe     <= 1'b1;
                r_be     <= r_rd_data;
                r_be_idx <= r_cmp_idx;
            end
            if (i_cmd.scan_init) begin
                r_idx <= '0;
                r_fa  <= 1'b0;
                r_fe  <= 1'b0;
            end
            if (i_cmd.pick) begin
                r_done[n_pick_idx] <= 1'b1;
                r_clock            <= n_comp;
                r_picks            <= r_picks + 1'b1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_picks <= '0;
                r_idx   <= '0;
                r_clock <= '0;
                r_done  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_pid   <= nps_pkg::t_pid'(n_pick_idx);
            r_start <= nps_pkg::t_time'(n_start);
            r_comp  <= nps_pkg::t_time'(n_comp);
            r_tat   <= nps_pkg::t_span'(n_tat);
            r_resp  <= nps_pkg::t_span'(n_resp);
            r_last  <= ((r_picks + 1'b1) == r_count);
        end
    end

    assign o_stat.scan_done = (r_idx == r_count) && !r_cmp_valid;
    assign o_stat.last_pick = r_last;

    assign o_process_id      = r_pid;
    assign o_start_time      = r_start;
    assign o_completion_time = r_comp;
    assign o_turnaround_time = r_tat;
    assign o_waiting_time    = r_resp;
    assign o_response_time   = r_resp;
    assign o_last_result     = r_last;

    `NPS_ASSERT_SAME(a_idx_bound, i_clk, i_rst_n, 1'b1, r_idx <= r_count)
    `NPS_ASSERT_SAME(a_pick_undone, i_clk, i_rst_n, i_cmd.pick, !r_done[n_pick_idx])

endmodule

`default_nettype wire

@@ rtl/nonpreemptive_process_scheduler.sv @@
// Top level: non-preemptive FCFS / SJF / priority scheduler.
`default_nettype none

// Process records are loaded one per cycle (ids are load order, records past
// MAX_PROCS are dropped). The record marked last starts the run: the block
// then produces one result per loaded process in dispatch order and accepts
// no new record until the final result is taken. Every pick scans the record
// memory one entry per cycle through its single read port, then the pick state
// registers the result. The policy register may be written whenever the block
// is idle; code three acts as FCFS.
module nonpreemptive_process_scheduler #(
    parameter int MAX_PROCS = nps_pkg::MAX_PROCS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire nps_pkg::t_policy i_cfg_policy,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire nps_pkg::t_tick  i_arrival_time,
    input  wire nps_pkg::t_tick  i_burst_time,
    input  wire nps_pkg::t_prio  i_priority_req,
    input  wire logic            i_last_process,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output nps_pkg::t_pid        o_process_id,
    output nps_pkg::t_time       o_start_time,
    output nps_pkg::t_time       o_completion_time,
    output nps_pkg::t_span       o_turnaround_time,
    output nps_pkg::t_span       o_waiting_time,
    output nps_pkg::t_span       o_response_time,
    output logic                 o_last_result
);

    nps_pkg::t_cmd  w_cmd;
    nps_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    nps_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_last_process (i_last_process),
        .i_out_ready    (i_out_ready),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid)
    );

    nps_dpath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_policy      (i_cfg_policy),
        .i_arrival_time    (i_arrival_time),
        .i_burst_time      (i_burst_time),
        .i_priority_req    (i_priority_req),
        .o_process_id      (o_process_id),
        .o_start_time      (o_start_time),
        .o_completion_time (o_completion_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_response_time   (o_response_time),
        .o_last_result     (o_last_result)
    );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for the non-preemptive process scheduler: directed and random process sets.
module testbench;

    localparam int NPROC = nps_pkg::MAX_PROCS_DEF;
    localparam nps_pkg::t_policy POL_FCFS_ALT = 2'd3;  // spare policy code, dispatches as FCFS
    localparam int SETTLE_CYCLES = 2 * NPROC + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 140;
    localparam int STREAM_ITEMS = 40;

    typedef struct {
        nps_pkg::t_pid  pid;
        nps_pkg::t_time start;
        nps_pkg::t_time done_at;
        nps_pkg::t_span turnaround;
        nps_pkg::t_span waiting;
        nps_pkg::t_span response;
        logic           last;
    } t_dispatch;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    nps_pkg::t_policy i_cfg_policy;
    logic             i_in_valid;
    logic             o_in_ready;
    nps_pkg::t_tick   i_arrival_time;
    nps_pkg::t_tick   i_burst_time;
    nps_pkg::t_prio   i_priority_req;
    logic             i_last_process;
    logic             o_out_valid;
    logic             i_out_ready;
    nps_pkg::t_pid    o_process_id;
    nps_pkg::t_time   o_start_time;
    nps_pkg::t_time   o_completion_time;
    nps_pkg::t_span   o_turnaround_time;
    nps_pkg::t_span   o_waiting_time;
    nps_pkg::t_span   o_response_time;
    logic             o_last_result;

    // Scheduler state mirrored on the bench side
    nps_pkg::t_tick   rec_arr[NPROC];
    nps_pkg::t_tick   rec_burst[NPROC];
    nps_pkg::t_prio   rec_prio[NPROC];
    int               rec_count;
    nps_pkg::t_policy cur_policy;
    t_dispatch        dispatch_q[$];

    int error_count;
    bit idle_on;
    bit run_live;
    int stall_left;
    int quiet_cycles;

    nonpreemptive_process_scheduler i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_policy      (i_cfg_policy),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_arrival_time    (i_arrival_time),
        .i_burst_time      (i_burst_time),
        .i_priority_req    (i_priority_req),
        .i_last_process    (i_last_process),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_process_id      (o_process_id),
        .o_start_time      (o_start_time),
        .o_completion_time (o_completion_time),
        .o_turnaround_time (o_turnaround_time),
        .o_waiting_time    (o_waiting_time),
        .o_response_time   (o_response_time),
        .o_last_result     (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    // True when process a is dispatched ahead of process b under the current policy
    function automatic bit goes_first(input int a, input int b);
        if (cur_policy == nps_pkg::POL_SJF) begin
            if (rec_burst[a] != rec_burst[b]) return rec_burst[a] < rec_burst[b];
            if (rec_arr[a] != rec_arr[b]) return rec_arr[a] < rec_arr[b];
            return a < b;
        end
        if (cur_policy == nps_pkg::POL_PRIO && rec_prio[a] != rec_prio[b])
            return rec_prio[a] > rec_prio[b];
        if (rec_arr[a] != rec_arr[b]) return rec_arr[a] < rec_arr[b];
        if (rec_burst[a] != rec_burst[b]) return rec_burst[a] < rec_burst[b];
        return a < b;
    endfunction

    // Run the loaded set to completion and queue one dispatch per process
    task automatic schedule_loaded();
        bit          finished[NPROC];
        int unsigned tick;
        int unsigned earliest;
        int          pick;
        bit          found;
        t_dispatch   r;
        tick = 0;
        foreach (finished[i]) finished[i] = 1'b0;
        for (int k = 0; k < rec_count; k++) begin
            found = 1'b0;
            earliest = 0;
            for (int i = 0; i < rec_count; i++) begin
                if (!finished[i] && (!found || rec_arr[i] < earliest)) begin
                    earliest = rec_arr[i];
                    found = 1'b1;
                end
            end
            // idle forward when nothing has arrived yet
            if (tick < earliest) tick = earliest;
            found = 1'b0;
            pick = 0;
            for (int i = 0; i < rec_count; i++) begin
                if (finished[i] || rec_arr[i] > tick) continue;
                if (!found || goes_first(i, pick)) begin
                    pick = i;
                    found = 1'b1;
                end
            end
            finished[pick] = 1'b1;
            r.pid        = nps_pkg::t_pid'(pick);
            r.start      = nps_pkg::t_time'(tick);
            r.response   = nps_pkg::t_span'(tick - rec_arr[pick]);
            tick         = tick + rec_burst[pick];
            r.done_at    = nps_pkg::t_time'(tick);
            r.turnaround = nps_pkg::t_span'(tick - rec_arr[pick]);
            r.waiting    = nps_pkg::t_span'(tick - rec_arr[pick] - rec_burst[pick]);
            r.last       = (k == rec_count - 1);
            dispatch_q.push_back(r);
        end
        rec_count = 0;
    endtask

    task automatic send_process(input nps_pkg::t_tick arr, input nps_pkg::t_tick burst,
                                input nps_pkg::t_prio prio, input logic last);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_arrival_time <= arr;
        i_burst_time   <= burst;
        i_priority_req <= prio;
        i_last_process <= last;
        do @(posedge i_clk); while (!o_in_ready);
        // drop records past the table size, but honor their last mark
        if (rec_count < NPROC) begin
            rec_arr[rec_count]   = arr;
            rec_burst[rec_count] = burst;
            rec_prio[rec_count]  = prio;
            rec_count++;
        end
        if (last) schedule_loaded();
    endtask

    task automatic write_policy(input nps_pkg::t_policy pol);
        @(negedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_cfg_policy <= pol;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_policy = pol;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Release the input, wait for every dispatch, then let the block settle
    task automatic finish_set();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (dispatch_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_set_size();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 13) return $urandom_range(1, 5);
        if (roll < 16) return $urandom_range(6, NPROC - 1);
        if (roll < 18) return NPROC;
        return $urandom_range(NPROC + 1, NPROC + 3);
    endfunction

    task automatic send_random_set(input int size);
        int             mode;
        nps_pkg::t_tick arr;
        nps_pkg::t_tick burst;
        nps_pkg::t_prio prio;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < size; i++) begin
            case (mode)
                0: begin
                    // narrow ranges make ties on every key likely
                    arr   = $urandom_range(0, 15);
                    burst = $urandom_range(0, 7);
                    prio  = $urandom_range(0, 3);
                end
                1: begin
                    arr   = $urandom;
                    burst = $urandom;
                    prio  = $urandom;
                end
                default: begin
                    // spread arrivals against short bursts to leave idle holes
                    arr   = $urandom_range(0, 3000);
                    burst = $urandom_range(0, 300);
                    prio  = $urandom;
                end
            endcase
            send_process(arr, burst, prio, i == size - 1);
        end
    endtask

    // Full table under FCFS from reset, field extremes, then an extra record that
    // gets dropped but still carries the last mark
    task automatic test_overflow_extremes();
        for (int i = 0; i < NPROC; i++) begin
            case (i)
                0: send_process(16'hFFFF, 16'hFFFF, 8'h00, 1'b0);
                1: send_process(16'h0000, 16'h0000, 8'hFF, 1'b0);
                2: send_process(16'h0000, 16'hFFFF, 8'hFF, 1'b0);
                default: send_process(nps_pkg::t_tick'(i * 4096),
                                      nps_pkg::t_tick'(16'hFFFF - i),
                                      nps_pkg::t_prio'(i * 17), 1'b0);
            endcase
        end
        send_process(16'd1, 16'd1, 8'd1, 1'b1);
        finish_set();
    endtask

    task automatic test_shortest_first();
        write_policy(nps_pkg::POL_SJF);
        send_process(16'd10, 16'd5, 8'd0, 1'b0);
        send_process(16'd0, 16'd20, 8'd0, 1'b0);
        send_process(16'd3, 16'd5, 8'd0, 1'b0);
        send_process(16'd3, 16'd5, 8'd9, 1'b1);
        finish_set();
    endtask

    task automatic test_priority_first();
        write_policy(nps_pkg::POL_PRIO);
        send_process(16'd0, 16'd4, 8'd1, 1'b0);
        send_process(16'd1, 16'd3, 8'd200, 1'b0);
        send_process(16'd1, 16'd3, 8'd200, 1'b0);
        send_process(16'd50, 16'd1, 8'd255, 1'b1);
        finish_set();
    endtask

    task automatic test_spare_policy_code();
        write_policy(POL_FCFS_ALT);
        send_process(16'd100, 16'd2, 8'd7, 1'b0);
        send_process(16'd100, 16'd1, 8'd3, 1'b1);
        finish_set();
    endtask

    task automatic test_random_sets();
        int items;
        int size;
        items = 0;
        while (items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 0)
                write_policy(nps_pkg::t_policy'($urandom_range(0, 3)));
            idle_on = ($urandom_range(0, 3) != 0);
            size = pick_set_size();
            send_random_set(size);
            finish_set();
            items += size;
        end
    endtask

    // Sets back to back with no idling: the next set waits on the handshake
    task automatic test_back_to_back();
        int items;
        int size;
        items = 0;
        idle_on = 1'b0;
        write_policy(nps_pkg::POL_FCFS);
        while (items < STREAM_ITEMS) begin
            size = $urandom_range(1, 5);
            send_random_set(size);
            items += size;
        end
        finish_set();
    endtask

    // Result side: random stall bursts while idling is on
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(0, 12);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_dispatch want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (dispatch_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual process %0d",
                         $time, o_process_id);
                error_count++;
            end else begin
                want = dispatch_q.pop_front();
                check_field("process_id", want.pid, o_process_id);
                check_field("start_time", want.start, o_start_time);
                check_field("completion_time", want.done_at, o_completion_time);
                check_field("turnaround_time", want.turnaround, o_turnaround_time);
                check_field("waiting_time", want.waiting, o_waiting_time);
                check_field("response_time", want.response, o_response_time);
                check_field("last_result", want.last, o_last_result);
            end
        end
    end

    // Stop the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (run_live) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_policy   = nps_pkg::POL_FCFS;
        i_in_valid     = 1'b0;
        i_arrival_time = '0;
        i_burst_time   = '0;
        i_priority_req = '0;
        i_last_process = 1'b0;
        i_out_ready    = 1'b0;
        stall_left     = 0;
        quiet_cycles   = 0;
        rec_count      = 0;
        cur_policy     = nps_pkg::POL_FCFS;
        error_count    = 0;
        idle_on        = 1'b1;
        run_live       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        run_live <= 1'b1;

        test_overflow_extremes();
        test_shortest_first();
        test_priority_first();
        test_spare_policy_code();
        test_random_sets();
        test_back_to_back();

        if (error_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
